/* src/srbb_pkg.sv */
// ----------------------------------------------------------------------------
// srbb_pkg: shared types and codes for the sorted record block builder
// Word types for the command and result channels, mode and status codes.
// ----------------------------------------------------------------------------
package srbb_pkg;

    localparam logic [1:0] MODE_BYTE  = 2'd0;
    localparam logic [1:0] MODE_RDPAY = 2'd1;
    localparam logic [1:0] MODE_RDIDX = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    localparam logic [2:0] ST_STORED  = 3'd0;
    localparam logic [2:0] ST_REJECT  = 3'd1;
    localparam logic [2:0] ST_READ_OK = 3'd2;
    localparam logic [2:0] ST_RANGE   = 3'd3;
    localparam logic [2:0] ST_CLEARED = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] record_time;
        logic [11:0] record_length;
        logic [7:0]  data_byte;
        logic [11:0] read_position;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  read_byte;
        logic [31:0] entry_time;
        logic [12:0] entry_length;
        logic [12:0] entry_offset;
        logic [8:0]  record_count;
        logic [31:0] earliest_time;
        logic [31:0] latest_time;
        logic [12:0] free_bytes;
    } rsp_t;

endpackage

/* src/srbb_ram.sv */
// ----------------------------------------------------------------------------
// srbb_ram: generic single-port synchronous RAM
// One write or one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module srbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write first port behavior is not relied on; read returns old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* src/sorted_record_block_builder.sv */
// ----------------------------------------------------------------------------
// sorted_record_block_builder: time-sorted slotted body store
// Payload bytes packed downward, a sorted index packed upward.
// ----------------------------------------------------------------------------
// A word is accepted when start is high and busy is low; at most one result
// word follows, marked by done for one cycle, and the receiver cannot stall it.
// A payload byte passes through S_PWAIT, a read through S_IWAIT, a clear
// through S_RESP. A record start runs a binary search over the index memory
// (S_SRCH issues a read, S_SCMP compares), then moves each entry from the
// insert point up one slot by one read and one write of the single-port index
// memory each, then writes the entry in S_INS; most entries move when the new time is the smallest.
// ----------------------------------------------------------------------------
module sorted_record_block_builder #(
    parameter int BODY_BYTES        = 4096,
    parameter int INDEX_ENTRY_BYTES = 16,
    parameter int MAX_ENTRIES       = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  srbb_pkg::cmd_t cmd,
    output logic           busy,
    output logic           done,
    output srbb_pkg::rsp_t rsp
);

    localparam int PW = $clog2(BODY_BYTES);
    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int HW = PW + 1;   // holds BODY_BYTES itself
    localparam int CW = IW + 1;   // holds MAX_ENTRIES itself
    localparam int EW = 32 + 13 + 13;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PWAIT  = 4'd1;
    localparam logic [3:0] S_IWAIT  = 4'd2;
    localparam logic [3:0] S_SRCH   = 4'd3;
    localparam logic [3:0] S_SCMP   = 4'd4;
    localparam logic [3:0] S_SHRD   = 4'd5;
    localparam logic [3:0] S_SHWR   = 4'd6;
    localparam logic [3:0] S_INS    = 4'd7;
    localparam logic [3:0] S_RESP   = 4'd8;

    logic [3:0]    state_reg, state_next;
    srbb_pkg::cmd_t cmd_reg, cmd_next;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   min_reg, min_next, max_reg, max_next;
    logic [HW-1:0] head_reg, head_next;
    logic [HW-1:0] used_reg, used_next;
    logic [12:0]   remain_reg, remain_next;
    logic [1:0]    phase_reg, phase_next;
    logic [HW-1:0] wpos_reg, wpos_next;
    logic [CW-1:0] lo_reg, lo_next, n_reg, n_next, half_reg, half_next;
    logic [CW-1:0] sh_reg, sh_next;
    logic          rej_reg, rej_next;
    logic          done_reg, done_next;
    srbb_pkg::rsp_t rsp_reg, rsp_next;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_STORE = 2'd1;
    localparam logic [1:0] PH_DROP  = 2'd2;

    // Memory ports.
    logic          pay_we;
    logic [PW-1:0] pay_addr;
    logic [7:0]    pay_wdata, pay_rdata;
    logic          idx_we;
    logic [IW-1:0] idx_addr;
    logic [EW-1:0] idx_wdata, idx_rdata;

    srbb_ram #(.WIDTH(8), .DEPTH(BODY_BYTES)) u_pay (
        .clk(clk), .we(pay_we), .addr(pay_addr), .wdata(pay_wdata), .rdata(pay_rdata)
    );
    srbb_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_idx (
        .clk(clk), .we(idx_we), .addr(idx_addr), .wdata(idx_wdata), .rdata(idx_rdata)
    );

    logic [HW-1:0] gap;
    logic [HW:0]   need;
    logic          fits;
    logic [12:0]   len13;
    logic [HW-1:0] len_h;
    logic [HW-1:0] new_head;

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // Space check for a new record.
    always_comb
    begin
        len13    = {1'b0, cmd_reg.record_length};
        len_h    = HW'(cmd_reg.record_length);
        gap      = (head_reg >= used_reg) ? (head_reg - used_reg) : '0;
        need     = (HW+1)'(INDEX_ENTRY_BYTES) + {1'b0, len_h};
        fits     = (count_reg < CW'(MAX_ENTRIES)) && (head_reg >= used_reg)
                   && (need <= {1'b0, gap});
        new_head = head_reg - len_h;
    end

    // Main sequencer.
    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        count_next  = count_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        head_next   = head_reg;
        used_next   = used_reg;
        remain_next = remain_reg;
        phase_next  = phase_reg;
        wpos_next   = wpos_reg;
        lo_next     = lo_reg;
        n_next      = n_reg;
        half_next   = half_reg;
        sh_next     = sh_reg;
        rej_next    = rej_reg;
        done_next   = 1'b0;
        rsp_next    = rsp_reg;
        pay_we      = 1'b0;
        pay_addr    = cmd_reg.read_position[PW-1:0];
        pay_wdata   = cmd_reg.data_byte;
        idx_we      = 1'b0;
        idx_addr    = cmd_reg.read_position[IW-1:0];
        idx_wdata   = idx_rdata;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    case (cmd.mode)
                        srbb_pkg::MODE_BYTE:
                        begin
                            if (remain_reg != '0)
                            begin
                                // Continuation byte: no result.
                                if (phase_reg == PH_STORE)
                                begin
                                    if (wpos_reg < HW'(BODY_BYTES))
                                    begin
                                        pay_we = 1'b1;
                                    end
                                    pay_addr  = wpos_reg[PW-1:0];
                                    pay_wdata = cmd.data_byte;
                                    wpos_next = wpos_reg + 1'b1;
                                end
                                remain_next = remain_reg - 1'b1;
                                if (remain_reg == 13'd1)
                                begin
                                    phase_next = PH_IDLE;
                                end
                                state_next = S_PWAIT;
                            end
                            else
                            begin
                                lo_next    = '0;
                                n_next     = count_reg;
                                state_next = S_SRCH;
                            end
                        end
                        srbb_pkg::MODE_RDPAY:
                        begin
                            pay_addr   = cmd.read_position[PW-1:0];
                            state_next = S_IWAIT;
                        end
                        srbb_pkg::MODE_RDIDX:
                        begin
                            idx_addr   = cmd.read_position[IW-1:0];
                            state_next = S_IWAIT;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_PWAIT:
            begin
                state_next = S_IDLE;
            end

            // Read data arrives; build the result.
            S_IWAIT:
            begin
                rsp_next = '0;
                if (cmd_reg.mode == srbb_pkg::MODE_RDPAY)
                begin
                    if ((HW'(cmd_reg.read_position) >= head_reg)
                        && (HW'(cmd_reg.read_position) < HW'(BODY_BYTES)))
                    begin
                        rsp_next.status    = srbb_pkg::ST_READ_OK;
                        rsp_next.read_byte = pay_rdata;
                    end
                    else
                    begin
                        rsp_next.status = srbb_pkg::ST_RANGE;
                    end
                end
                else
                begin
                    if ((13'(cmd_reg.read_position) < 13'(count_reg))
                        && (13'(cmd_reg.read_position) < 13'(MAX_ENTRIES)))
                    begin
                        rsp_next.status       = srbb_pkg::ST_READ_OK;
                        rsp_next.entry_time   = idx_rdata[EW-1 -: 32];
                        rsp_next.entry_length = idx_rdata[25:13];
                        rsp_next.entry_offset = idx_rdata[12:0];
                    end
                    else
                    begin
                        rsp_next.status = srbb_pkg::ST_RANGE;
                    end
                end
                rsp_next.record_count  = 9'(count_reg);
                rsp_next.earliest_time = min_reg;
                rsp_next.latest_time   = max_reg;
                rsp_next.free_bytes    = 13'(gap);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            // Space check, then binary search: issue a read at lo + n/2 until n is zero.
            S_SRCH:
            begin
                if (!fits)
                begin
                    // A rejected record still consumes its bytes.
                    rej_next    = 1'b1;
                    remain_next = (len13 != '0) ? (len13 - 1'b1) : '0;
                    phase_next  = (len13 > 13'd1) ? PH_DROP : PH_IDLE;
                    state_next  = S_RESP;
                end
                else if (n_reg == '0)
                begin
                    sh_next    = count_reg;
                    state_next = (count_reg == lo_reg) ? S_INS : S_SHRD;
                end
                else
                begin
                    half_next  = n_reg >> 1;
                    idx_addr   = IW'(lo_reg + (n_reg >> 1));
                    state_next = S_SCMP;
                end
            end

            S_SCMP:
            begin
                if (idx_rdata[EW-1 -: 32] < cmd_reg.record_time)
                begin
                    lo_next = lo_reg + half_reg + 1'b1;
                    n_next  = n_reg - half_reg - 1'b1;
                end
                else
                begin
                    n_next = half_reg;
                end
                state_next = S_SRCH;
            end

            // Shift entries up: read sh-1, then write it at sh.
            S_SHRD:
            begin
                idx_addr   = IW'(sh_reg - 1'b1);
                state_next = S_SHWR;
            end

            S_SHWR:
            begin
                idx_we    = 1'b1;
                idx_addr  = IW'(sh_reg);
                idx_wdata = idx_rdata;
                sh_next   = sh_reg - 1'b1;
                state_next = ((sh_reg - 1'b1) == lo_reg) ? S_INS : S_SHRD;
            end

            // Write the new entry, reserve space, store the first byte if there is one.
            S_INS:
            begin
                rej_next  = 1'b0;
                idx_we    = 1'b1;
                idx_addr  = IW'(lo_reg);
                idx_wdata = {cmd_reg.record_time, len13, 13'(new_head)};
                head_next  = new_head;
                count_next = count_reg + 1'b1;
                used_next  = used_reg + HW'(INDEX_ENTRY_BYTES);
                if (cmd_reg.record_time < min_reg)
                begin
                    min_next = cmd_reg.record_time;
                end
                if (cmd_reg.record_time > max_reg)
                begin
                    max_next = cmd_reg.record_time;
                end
                wpos_next  = new_head;
                phase_next = PH_IDLE;
                if (len13 != '0)
                begin
                    pay_we      = (new_head < HW'(BODY_BYTES));
                    pay_addr    = new_head[PW-1:0];
                    wpos_next   = new_head + 1'b1;
                    remain_next = len13 - 1'b1;
                    if (len13 != 13'd1)
                    begin
                        phase_next = PH_STORE;
                    end
                end
                state_next = S_RESP;
            end

            // Results of record start and clear; a clear also resets the store.
            S_RESP:
            begin
                rsp_next = '0;
                if (cmd_reg.mode == srbb_pkg::MODE_CLEAR)
                begin
                    count_next  = '0;
                    min_next    = '1;
                    max_next    = '0;
                    head_next   = HW'(BODY_BYTES);
                    used_next   = '0;
                    remain_next = '0;
                    phase_next  = PH_IDLE;
                    wpos_next   = '0;
                    rsp_next.status        = srbb_pkg::ST_CLEARED;
                    rsp_next.record_count  = '0;
                    rsp_next.earliest_time = '1;
                    rsp_next.latest_time   = '0;
                    rsp_next.free_bytes    = 13'(BODY_BYTES);
                end
                else
                begin
                    rsp_next.status        = rej_reg ? srbb_pkg::ST_REJECT
                                                     : srbb_pkg::ST_STORED;
                    rsp_next.record_count  = 9'(count_reg);
                    rsp_next.earliest_time = min_reg;
                    rsp_next.latest_time   = max_reg;
                    rsp_next.free_bytes    = 13'(gap);
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            min_reg    <= '1;
            max_reg    <= '0;
            head_reg   <= HW'(BODY_BYTES);
            used_reg   <= '0;
            remain_reg <= '0;
            phase_reg  <= PH_IDLE;
            wpos_reg   <= '0;
            done_reg   <= 1'b0;
            rsp_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            min_reg    <= min_next;
            max_reg    <= max_next;
            head_reg   <= head_next;
            used_reg   <= used_next;
            remain_reg <= remain_next;
            phase_reg  <= phase_next;
            wpos_reg   <= wpos_next;
            done_reg   <= done_next;
            rsp_reg    <= rsp_next;
        end
    end

    // Working registers without reset.
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        lo_reg   <= lo_next;
        n_reg    <= n_next;
        half_reg <= half_next;
        sh_reg   <= sh_next;
        rej_reg  <= rej_next;
    end

endmodule

/* dv/sorted_record_block_builder_tb.sv */
// ----------------------------------------------------------------------------
// sorted_record_block_builder_tb: self-checking bench for the record builder
// Drives command words under random gaps, predicts every result word from a
// behavioral copy of the body store and its sorted index, and checks each
// result field by field in order.
// ----------------------------------------------------------------------------
module sorted_record_block_builder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BODY      = 4096;
    localparam int ENTRY_SZ  = 16;
    localparam int MAX_ENT   = 256;
    localparam int PH_IDLE   = 0;
    localparam int PH_STORE  = 1;
    localparam int PH_DROP   = 2;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    srbb_pkg::cmd_t cmd = '0;
    logic busy;
    logic done;
    srbb_pkg::rsp_t rsp;

    sorted_record_block_builder uut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    always #5 clk = ~clk;

    // Shadow copy of the block contents.
    logic [7:0]  pay_mem [BODY];
    bit          pay_written [BODY];
    logic [31:0] ix_time [MAX_ENT];
    logic [12:0] ix_len [MAX_ENT];
    logic [12:0] ix_off [MAX_ENT];
    int unsigned n_entries;
    logic [31:0] t_min;
    logic [31:0] t_max;
    int unsigned head;
    int unsigned ix_bytes;
    int unsigned left_bytes;
    int          phase;
    int unsigned wr_ptr;

    srbb_pkg::cmd_t pending_words[$];
    srbb_pkg::rsp_t expected_words[$];
    int   error_count = 0;
    bit   quiet_tail = 1'b0;

    task automatic report(input string what);
        error_count++;
        $display("%0t mismatch: %s", $realtime, what);
    endtask

    function automatic void clear_shadow();
        n_entries = 0;
        t_min = '1;
        t_max = '0;
        head = BODY;
        ix_bytes = 0;
        left_bytes = 0;
        phase = PH_IDLE;
        wr_ptr = 0;
    endfunction

    function automatic void put_payload(input logic [7:0] b);
        if (wr_ptr < BODY)
        begin
            pay_mem[wr_ptr] = b;
            pay_written[wr_ptr] = 1'b1;
        end
        wr_ptr++;
    endfunction

    // Lower-bound insertion of a new index entry.
    function automatic void insert_sorted(input logic [31:0] t, input int unsigned len,
                                          input int unsigned off);
        int unsigned lo;
        int unsigned n;
        int unsigned half;
        lo = 0;
        n = n_entries;
        while (n > 0)
        begin
            half = n / 2;
            if (ix_time[lo + half] < t)
            begin
                lo += half + 1;
                n -= half + 1;
            end
            else
                n = half;
        end
        for (int unsigned i = n_entries; i > lo; i--)
        begin
            ix_time[i] = ix_time[i - 1];
            ix_len[i] = ix_len[i - 1];
            ix_off[i] = ix_off[i - 1];
        end
        ix_time[lo] = t;
        ix_len[lo] = 13'(len);
        ix_off[lo] = 13'(off);
        n_entries++;
        ix_bytes += ENTRY_SZ;
        if (t < t_min) t_min = t;
        if (t > t_max) t_max = t;
    endfunction

    // Applies one word to the shadow and returns whether a result follows.
    function automatic bit predict_word(input srbb_pkg::cmd_t c, output srbb_pkg::rsp_t r);
        int unsigned len;
        r = '0;
        len = 32'(c.record_length);
        case (c.mode)
            srbb_pkg::MODE_BYTE:
            begin
                if (left_bytes != 0)
                begin
                    if (phase == PH_STORE) put_payload(c.data_byte);
                    left_bytes--;
                    if (left_bytes == 0) phase = PH_IDLE;
                    return 1'b0;
                end
                phase = PH_IDLE;
                if (n_entries < MAX_ENT && head >= ix_bytes &&
                    ENTRY_SZ + len <= head - ix_bytes)
                begin
                    head -= len;
                    wr_ptr = head;
                    insert_sorted(c.record_time, len, head);
                    if (len > 0)
                    begin
                        put_payload(c.data_byte);
                        left_bytes = len - 1;
                        if (left_bytes != 0) phase = PH_STORE;
                    end
                    r.status = srbb_pkg::ST_STORED;
                end
                else
                begin
                    if (len > 0)
                    begin
                        left_bytes = len - 1;
                        if (left_bytes != 0) phase = PH_DROP;
                    end
                    r.status = srbb_pkg::ST_REJECT;
                end
            end
            srbb_pkg::MODE_RDPAY:
            begin
                if (c.read_position >= head && c.read_position < BODY)
                begin
                    r.status = srbb_pkg::ST_READ_OK;
                    r.read_byte = pay_mem[c.read_position];
                end
                else
                    r.status = srbb_pkg::ST_RANGE;
            end
            srbb_pkg::MODE_RDIDX:
            begin
                if (c.read_position < n_entries)
                begin
                    r.status = srbb_pkg::ST_READ_OK;
                    r.entry_time = ix_time[c.read_position];
                    r.entry_length = ix_len[c.read_position];
                    r.entry_offset = ix_off[c.read_position];
                end
                else
                    r.status = srbb_pkg::ST_RANGE;
            end
            default:
            begin
                clear_shadow();
                r.status = srbb_pkg::ST_CLEARED;
            end
        endcase
        r.record_count = 9'(n_entries);
        r.earliest_time = t_min;
        r.latest_time = t_max;
        r.free_bytes = (head >= ix_bytes) ? 13'(head - ix_bytes) : '0;
        return 1'b1;
    endfunction

    // Random read position; payload reads only touch bytes already written.
    function automatic logic [11:0] pick_position(input logic [1:0] m);
        int unsigned p;
        if (m == srbb_pkg::MODE_RDPAY)
        begin
            for (int k = 0; k < 8; k++)
            begin
                p = $urandom_range(BODY - 1);
                if ($urandom_range(3) != 0 && head < BODY) p = $urandom_range(BODY - 1, head);
                if (p < head || pay_written[p]) return 12'(p);
            end
            return (head > 0) ? 12'd0 : 12'd4095;
        end
        if ($urandom_range(3) != 0 && n_entries > 0) return 12'($urandom_range(n_entries - 1));
        return 12'($urandom_range(4095));
    endfunction

    // Builds a word, predicts it at build time (order of issue equals order of acceptance).
    task automatic push_word(input logic [1:0] m, input logic [31:0] t, input logic [11:0] len,
                             input logic [7:0] b, input logic [11:0] pos);
        srbb_pkg::cmd_t c;
        srbb_pkg::rsp_t r;
        c.mode = m;
        c.record_time = t;
        c.record_length = len;
        c.data_byte = b;
        c.read_position = (m == srbb_pkg::MODE_RDPAY || m == srbb_pkg::MODE_RDIDX)
                          ? pick_position(m) : pos;
        if (m == srbb_pkg::MODE_RDPAY && pos != 12'hfff) c.read_position = pos;
        if (predict_word(c, r)) expected_words.push_back(r);
        pending_words.push_back(c);
    endtask

    // A full record: start word, its bytes, and a few reads mixed in.
    task automatic push_record(input logic [31:0] t, input logic [11:0] len);
        push_word(srbb_pkg::MODE_BYTE, t, len, 8'($urandom), 12'($urandom));
        for (int i = 1; i < int'(len); i++)
        begin
            if ($urandom_range(15) == 0)
                push_word(2'($urandom_range(2, 1)), $urandom, 12'($urandom),
                          8'($urandom), 12'hfff);
            push_word(srbb_pkg::MODE_BYTE, $urandom, 12'($urandom), 8'($urandom),
                      12'($urandom));
        end
    endtask

    function automatic logic [31:0] pick_time();
        case ($urandom_range(4))
            0: return '0;
            1: return '1;
            2: return $urandom_range(20);
            default: return $urandom;
        endcase
    endfunction

    // Driver: holds start high until busy is low at an edge.
    int gap = 0;
    always @(posedge clk)
    begin
        if (start && !busy)
        begin
            if (pending_words.size() > 0 && gap == 0 &&
                (quiet_tail || $urandom_range(5) != 0))
            begin
                cmd <= pending_words.pop_front();
                start <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
                if (!quiet_tail && $urandom_range(1)) gap = $urandom_range(8, 1);
            end
        end
        else if (!start)
        begin
            if (gap > 0)
                gap--;
            else if (pending_words.size() > 0 && rst_n)
            begin
                cmd <= pending_words.pop_front();
                start <= 1'b1;
            end
        end
    end

    // Monitor: compares each result word with the oldest prediction.
    always @(posedge clk)
    begin
        srbb_pkg::rsp_t e;
        if (rst_n && done)
        begin
            if (expected_words.size() == 0)
                report("result word with none expected");
            else
            begin
                e = expected_words.pop_front();
                if (rsp.status !== e.status)
                    report($sformatf("status %0d exp %0d", rsp.status, e.status));
                if (rsp.read_byte !== e.read_byte)
                    report($sformatf("read_byte %0h exp %0h", rsp.read_byte, e.read_byte));
                if (rsp.entry_time !== e.entry_time)
                    report($sformatf("entry_time %0h exp %0h",
                                     rsp.entry_time, e.entry_time));
                if (rsp.entry_length !== e.entry_length)
                    report($sformatf("entry_length %0d exp %0d",
                                     rsp.entry_length, e.entry_length));
                if (rsp.entry_offset !== e.entry_offset)
                    report($sformatf("entry_offset %0d exp %0d",
                                     rsp.entry_offset, e.entry_offset));
                if (rsp.record_count !== e.record_count)
                    report($sformatf("record_count %0d exp %0d",
                                     rsp.record_count, e.record_count));
                if (rsp.earliest_time !== e.earliest_time)
                    report($sformatf("earliest_time %0h exp %0h",
                                     rsp.earliest_time, e.earliest_time));
                if (rsp.latest_time !== e.latest_time)
                    report($sformatf("latest_time %0h exp %0h",
                                     rsp.latest_time, e.latest_time));
                if (rsp.free_bytes !== e.free_bytes)
                    report($sformatf("free_bytes %0d exp %0d",
                                     rsp.free_bytes, e.free_bytes));
            end
        end
    end

    initial
    begin
        int unsigned roll;
        for (int i = 0; i < BODY; i++) pay_written[i] = 1'b0;
        clear_shadow();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty reads, zero-length and extreme records, equal times,
        // a read of a reserved byte, clear in mid-record, oversize reject.
        push_word(srbb_pkg::MODE_RDIDX, '0, '0, '0, 12'hfff);
        push_word(srbb_pkg::MODE_RDPAY, '0, '0, '0, 12'd4095);
        push_word(srbb_pkg::MODE_BYTE, 32'hffffffff, 12'd0, 8'hff, 12'd0);
        push_word(srbb_pkg::MODE_BYTE, 32'd0, 12'd1, 8'h00, 12'hfff);
        push_record(32'd7, 12'd3);
        push_record(32'd7, 12'd2);
        push_word(srbb_pkg::MODE_BYTE, 32'd5, 12'd4, 8'h5a, 12'd0);
        push_word(srbb_pkg::MODE_RDPAY, '0, '0, '0, 12'(head));
        push_word(srbb_pkg::MODE_BYTE, '0, '0, 8'ha5, '0);
        push_word(srbb_pkg::MODE_CLEAR, '0, '0, '0, '0);
        push_word(srbb_pkg::MODE_BYTE, 32'd9, 12'd4095, 8'h11, 12'd0);
        push_word(srbb_pkg::MODE_BYTE, '0, '0, 8'h22, '0);
        push_word(srbb_pkg::MODE_CLEAR, '0, '0, '0, '0);
        push_record(32'h80000000, 12'd400);
        for (int i = 0; i < 4; i++) push_word(srbb_pkg::MODE_RDIDX, '0, '0, '0, 12'hfff);
        push_word(srbb_pkg::MODE_RDPAY, '0, '0, '0, 12'd4095);
        push_word(srbb_pkg::MODE_RDPAY, '0, '0, '0, 12'd0);
        push_word(srbb_pkg::MODE_CLEAR, '0, '0, '0, '0);

        // Random: mostly short records, reads and the occasional clear.
        while (pending_words.size() < 1350)
        begin
            roll = $urandom_range(99);
            if (roll < 50)
                push_record(pick_time(), ($urandom_range(15) == 0) ? 12'($urandom_range(600))
                                                                   : 12'($urandom_range(6)));
            else if (roll < 90)
                push_word(2'($urandom_range(2, 1)), $urandom, 12'($urandom), 8'($urandom),
                          12'hfff);
            else if (roll < 92)
                push_word(srbb_pkg::MODE_CLEAR, $urandom, 12'($urandom), 8'($urandom),
                          12'($urandom));
            else
                push_word(srbb_pkg::MODE_BYTE, $urandom, 12'($urandom), 8'($urandom),
                          12'($urandom));
        end
        // Fill the index to its entry limit with zero-length records, then go past it.
        push_word(srbb_pkg::MODE_CLEAR, '0, '0, '0, '0);
        for (int i = 0; i < 258; i++) push_word(srbb_pkg::MODE_BYTE, $urandom, 12'd0, '0, '0);
        for (int i = 0; i < 20; i++) push_word(srbb_pkg::MODE_RDIDX, '0, '0, '0, 12'hfff);

        wait (pending_words.size() < 300);
        quiet_tail = 1'b1;
        wait (pending_words.size() == 0 && expected_words.size() == 0);
        repeat (600) @(posedge clk);
        if (error_count == 0 && expected_words.size() == 0)
            $display("sorted_record_block_builder_tb: clean");
        else
            $display("sorted_record_block_builder_tb: errors");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("sorted_record_block_builder_tb: errors");
        $finish;
    end

endmodule
